@@ design/gcd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the great-circle distance block.
// No dependencies; every other design file refers to it by scoped names.

package gcd_pkg;

	// datapath widths
	localparam int DW = 33;   // reduced-angle input, degrees Q23
	localparam int XW = 34;   // CORDIC x/y and Q30 products
	localparam int ZW = 33;   // CORDIC angle accumulator, radians Q30
	localparam int RW = 31;   // Q30 values in [0,1], square roots
	localparam int SQRT_STEPS = 31;

	localparam logic signed [XW-1:0] INV_GAIN = XW'(32'h26DD3B6A);
	localparam logic [RW-1:0] Q30_ONE = RW'(32'h40000000);
	localparam logic [RW-1:0] HALF_PI = RW'(32'd1686629713);
	localparam logic [31:0] DEG_RAD_Q37 = 32'd2398762259;
	localparam logic [32:0] MILES_Q20 = 33'd8302110213;
	localparam logic [21:0] DIST_MAX = 22'h3FFFFF;

	typedef logic signed [XW-1:0] cord_t;
	typedef logic signed [ZW-1:0] ang_t;

	// truncated arctangent table, Q30 radians
	function automatic ang_t atan_q30(input logic [4:0] i);
		ang_t r;
		unique case (i)
			5'd0:  r = ZW'(30'h3243F6A8);
			5'd1:  r = ZW'(30'h1DAC6705);
			5'd2:  r = ZW'(30'h0FADBAFC);
			5'd3:  r = ZW'(30'h07F56EA6);
			5'd4:  r = ZW'(30'h03FEAB76);
			5'd5:  r = ZW'(30'h01FFD55B);
			5'd6:  r = ZW'(30'h00FFFAAA);
			5'd7:  r = ZW'(30'h007FFF55);
			5'd8:  r = ZW'(30'h003FFFEA);
			5'd9:  r = ZW'(30'h001FFFFD);
			5'd10: r = ZW'(30'h000FFFFF);
			5'd11: r = ZW'(30'h0007FFFF);
			5'd12: r = ZW'(30'h0003FFFF);
			5'd13: r = ZW'(30'h0001FFFF);
			5'd14: r = ZW'(30'h0000FFFF);
			5'd15: r = ZW'(30'h00007FFF);
			5'd16: r = ZW'(30'h00003FFF);
			5'd17: r = ZW'(30'h00001FFF);
			5'd18: r = ZW'(30'h00000FFF);
			5'd19: r = ZW'(30'h000007FF);
			5'd20: r = ZW'(30'h000003FF);
			5'd21: r = ZW'(30'h000001FF);
			5'd22: r = ZW'(30'h000000FF);
			5'd23: r = ZW'(30'h0000007F);
			5'd24: r = ZW'(30'h0000003F);
			5'd25: r = ZW'(30'h0000001F);
			5'd26: r = ZW'(30'h0000000F);
			5'd27: r = ZW'(30'h00000008);
			5'd28: r = ZW'(30'h00000004);
			5'd29: r = ZW'(30'h00000002);
			5'd30: r = ZW'(30'h00000001);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 product with round-half-up, floor shift
	function automatic cord_t mul_q30(input cord_t p, input cord_t q);
		logic signed [2*XW-1:0] prod;
		prod = p * q;
		prod = prod + (2*XW)'(32'h20000000);
		return XW'(prod >>> 30);
	endfunction

endpackage

@@ design/gcd_sincos.sv @@
// Pipelined sine/cosine: angle reduction, degree-to-radian scaling, rotation CORDIC.
// Depends on gcd_pkg. The pipeline advances when en is high.

module gcd_sincos #(
	parameter int STAGES = 24
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [gcd_pkg::DW-1:0]      deg,
	output gcd_pkg::cord_t                     sin_q30,
	output gcd_pkg::cord_t                     cos_q30
);

	function automatic logic [7:0] mod45(input logic [7:0] v);
		logic [7:0] r;
		priority if (v >= 8'd180) r = v - 8'd180;
		else if (v >= 8'd135)     r = v - 8'd135;
		else if (v >= 8'd90)      r = v - 8'd90;
		else if (v >= 8'd45)      r = v - 8'd45;
		else                      r = v;
		return r;
	endfunction

	// reduce modulo a full turn (45 * 2^26), split into quadrant and remainder
	logic signed [8:0] hsum;
	logic [7:0] hmod, kq;
	logic [1:0] quad;
	logic [7:0] krem;
	logic [29:0] t_s1;
	logic [1:0]  q_s1;

	always_comb begin
		hsum = 9'(signed'(deg[gcd_pkg::DW-1:26])) + 9'sd135;
		hmod = mod45(hsum[7:0]);
		kq   = 8'({hmod[5:0], deg[25:24]});
		priority if (kq >= 8'd135) quad = 2'd3;
		else if (kq >= 8'd90)      quad = 2'd2;
		else if (kq >= 8'd45)      quad = 2'd1;
		else                       quad = 2'd0;
		krem = kq - 8'(quad) * 8'd45;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= {krem[5:0], deg[23:0]};
			q_s1 <= quad;
		end
	end

	// degrees Q23 to radians Q30
	logic [62:0] zprod;
	gcd_pkg::ang_t z_s2;
	logic [1:0]    q_s2;

	assign zprod = 63'(t_s1) * 63'(gcd_pkg::DEG_RAD_Q37) + 63'(32'h20000000);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= gcd_pkg::ZW'(zprod[61:30]);
			q_s2 <= q_s1;
		end
	end

	// rotation CORDIC, one micro-rotation per stage
	gcd_pkg::cord_t x_s [STAGES];
	gcd_pkg::cord_t y_s [STAGES];
	gcd_pkg::ang_t  z_s [STAGES];
	logic [1:0]     q_s [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_rot
		gcd_pkg::cord_t xi, yi, xsh, ysh;
		gcd_pkg::ang_t  zi;
		logic [1:0]     qi;
		if (j == 0) begin : g_first
			assign xi = gcd_pkg::INV_GAIN;
			assign yi = '0;
			assign zi = z_s2;
			assign qi = q_s2;
		end else begin : g_next
			assign xi = x_s[j-1];
			assign yi = y_s[j-1];
			assign zi = z_s[j-1];
			assign qi = q_s[j-1];
		end
		assign xsh = xi >>> j;
		assign ysh = yi >>> j;
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_s[j] <= xi - ysh;
					y_s[j] <= yi + xsh;
					z_s[j] <= zi - gcd_pkg::atan_q30(5'(j));
				end else begin
					x_s[j] <= xi + ysh;
					y_s[j] <= yi - xsh;
					z_s[j] <= zi + gcd_pkg::atan_q30(5'(j));
				end
				q_s[j] <= qi;
			end
		end
	end

	// quadrant fix-up
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[STAGES-1])
				2'd0: begin
					sin_q30 <= y_s[STAGES-1];
					cos_q30 <= x_s[STAGES-1];
				end
				2'd1: begin
					sin_q30 <= x_s[STAGES-1];
					cos_q30 <= -y_s[STAGES-1];
				end
				2'd2: begin
					sin_q30 <= -y_s[STAGES-1];
					cos_q30 <= -x_s[STAGES-1];
				end
				default: begin
					sin_q30 <= -x_s[STAGES-1];
					cos_q30 <= y_s[STAGES-1];
				end
			endcase
		end
	end

endmodule

@@ design/gcd_isqrt.sv @@
// Pipelined exact square root of a Q30 value: floor(sqrt(v * 2^30)), one result bit a stage.
// Depends on gcd_pkg. The pipeline advances when en is high.

module gcd_isqrt (
	input  logic                    clk,
	input  logic                    en,
	input  logic [gcd_pkg::RW-1:0]  rad,
	output logic [gcd_pkg::RW-1:0]  root
);

	localparam int N = gcd_pkg::SQRT_STEPS;
	localparam int NW = 2 * N;

	logic [NW-1:0] rem_s [N];
	logic [NW-1:0] res_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [NW-1:0] BIT = NW'(1) << (2 * (N - 1 - k));
		logic [NW-1:0] remi, resi, trial;
		if (k == 0) begin : g_first
			assign remi = NW'({rad, 30'b0});
			assign resi = '0;
		end else begin : g_next
			assign remi = rem_s[k-1];
			assign resi = res_s[k-1];
		end
		assign trial = resi + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (remi >= trial) begin
					rem_s[k] <= remi - trial;
					res_s[k] <= (resi >> 1) + BIT;
				end else begin
					rem_s[k] <= remi;
					res_s[k] <= resi >> 1;
				end
			end
		end
	end

	assign root = res_s[N-1][gcd_pkg::RW-1:0];

endmodule

@@ design/gcd_atan.sv @@
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians for non-negative x and y.
// Depends on gcd_pkg. The pipeline advances when en is high.

module gcd_atan #(
	parameter int STAGES = 24
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [gcd_pkg::RW-1:0]  x_in,
	input  logic [gcd_pkg::RW-1:0]  y_in,
	output gcd_pkg::ang_t           angle
);

	gcd_pkg::cord_t x_s [STAGES];
	gcd_pkg::cord_t y_s [STAGES];
	gcd_pkg::ang_t  z_s [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_vec
		gcd_pkg::cord_t xi, yi, xsh, ysh;
		gcd_pkg::ang_t  zi;
		if (j == 0) begin : g_first
			assign xi = gcd_pkg::XW'(x_in);
			assign yi = gcd_pkg::XW'(y_in);
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[j-1];
			assign yi = y_s[j-1];
			assign zi = z_s[j-1];
		end
		assign xsh = xi >>> j;
		assign ysh = yi >>> j;
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					x_s[j] <= xi + ysh;
					y_s[j] <= yi - xsh;
					z_s[j] <= zi + gcd_pkg::atan_q30(5'(j));
				end else begin
					x_s[j] <= xi - ysh;
					y_s[j] <= yi + xsh;
					z_s[j] <= zi - gcd_pkg::atan_q30(5'(j));
				end
			end
		end
	end

	assign angle = z_s[STAGES-1];

endmodule

@@ design/great_circle_distance.sv @@
// Top level of the haversine great-circle distance pipeline.
// Depends on gcd_pkg, gcd_sincos, gcd_isqrt and gcd_atan.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+--------------------------------------
//  input   | in_valid / in_ready | lat_a, lon_a, lat_b, lon_b (deg Q22)
//  output  | out_valid/out_ready | distance_miles (miles Q8, saturating)
//
// One transaction enters per cycle unless the output stalls; the pipeline depth is set by
// the two CORDIC chains (one stage per micro-rotation) and the 31-step square root.
// Reset clears only the valid bits travelling with the data.
// A stalled output freezes the whole pipeline in place; in_ready drops only while
// a finished result is held and not taken.

module great_circle_distance #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [29:0] lat_a,
	input  logic signed [30:0] lon_a,
	input  logic signed [29:0] lat_b,
	input  logic signed [30:0] lon_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [21:0]        distance_miles
);

	localparam int DW = gcd_pkg::DW;
	localparam int RW = gcd_pkg::RW;
	localparam int LAT = 2 * CORDIC_STAGES + gcd_pkg::SQRT_STEPS + 9;

	logic en;
	logic [LAT-1:0] vld_q;

	// pipeline advance and valid bits
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// angle differences, degrees Q23 (half differences exact); latitudes doubled
	logic signed [DW-1:0] dlat_s1, dlon_s1, lata_s1, latb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= DW'(lat_b) - DW'(lat_a);
			dlon_s1 <= DW'(lon_b) - DW'(lon_a);
			lata_s1 <= DW'(lat_a) <<< 1;
			latb_s1 <= DW'(lat_b) <<< 1;
		end
	end

	// trig of the four angles
	gcd_pkg::cord_t s_lat, s_lon, c_a, c_b;
	gcd_pkg::cord_t unused_c0, unused_c1, unused_s0, unused_s1;

	gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
		.clk(clk), .en(en), .deg(dlat_s1), .sin_q30(s_lat), .cos_q30(unused_c0)
	);
	gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
		.clk(clk), .en(en), .deg(dlon_s1), .sin_q30(s_lon), .cos_q30(unused_c1)
	);
	gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lata (
		.clk(clk), .en(en), .deg(lata_s1), .sin_q30(unused_s0), .cos_q30(c_a)
	);
	gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_latb (
		.clk(clk), .en(en), .deg(latb_s1), .sin_q30(unused_s1), .cos_q30(c_b)
	);

	// haversine term a over three stages
	gcd_pkg::cord_t p1_s2, p2_s2, p3_s2, p1_s3, p4_s3;
	logic [RW-1:0] a_s4, b_s4;
	logic signed [gcd_pkg::XW:0] asum;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2 <= gcd_pkg::mul_q30(s_lat, s_lat);
			p2_s2 <= gcd_pkg::mul_q30(c_a, c_b);
			p3_s2 <= gcd_pkg::mul_q30(s_lon, s_lon);
			p1_s3 <= p1_s2;
			p4_s3 <= gcd_pkg::mul_q30(p2_s2, p3_s2);
		end
	end

	assign asum = (gcd_pkg::XW+1)'(p1_s3) + (gcd_pkg::XW+1)'(p4_s3);

	// clamp a to [0,1] and form b = 1 - a
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (asum < 0) begin
				a_s4 <= '0;
				b_s4 <= gcd_pkg::Q30_ONE;
			end else if (asum > (gcd_pkg::XW+1)'(gcd_pkg::Q30_ONE)) begin
				a_s4 <= gcd_pkg::Q30_ONE;
				b_s4 <= '0;
			end else begin
				a_s4 <= RW'(asum);
				b_s4 <= gcd_pkg::Q30_ONE - RW'(asum);
			end
		end
	end

	// square roots and angle
	logic [RW-1:0] sq_a, sq_b;
	gcd_pkg::ang_t c_half;

	gcd_isqrt u_sqrt_a (.clk(clk), .en(en), .rad(a_s4), .root(sq_a));
	gcd_isqrt u_sqrt_b (.clk(clk), .en(en), .rad(b_s4), .root(sq_b));

	gcd_atan #(.STAGES(CORDIC_STAGES)) u_atan (
		.clk(clk), .en(en), .x_in(sq_b), .y_in(sq_a), .angle(c_half)
	);

	// clamp angle, split scale multiply into two partial products
	logic [RW-1:0] ang_c;
	logic [47:0] phi_s5;
	logic [46:0] plo_s5;

	always_comb begin
		priority if (c_half < 0)                         ang_c = '0;
		else if (c_half > gcd_pkg::ZW'(gcd_pkg::HALF_PI)) ang_c = gcd_pkg::HALF_PI;
		else                                             ang_c = RW'(c_half);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s5 <= 48'(ang_c) * 48'(gcd_pkg::MILES_Q20[32:16]);
			plo_s5 <= 47'(ang_c) * 47'(gcd_pkg::MILES_Q20[15:0]);
		end
	end

	// combine, round and saturate
	logic [64:0] dsum;
	logic [22:0] dq;

	assign dsum = {1'b0, phi_s5, 16'b0} + 65'(plo_s5) + (65'(1) << 41);
	assign dq   = dsum[64:42];

	always_ff @(posedge clk) begin
		if (en) begin
			distance_miles <= (dq > 23'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : dq[21:0];
		end
	end

endmodule

@@ verif/tb_great_circle_distance.sv @@
// Testbench for great_circle_distance: random and directed coordinate pairs,
// with a scoreboard holding the predicted distances. Needs only the design files.
`timescale 1ns / 100ps

module tb_great_circle_distance;

	localparam int N_RANDOM = 2000;
	localparam int LATENCY = 2 * 24 + 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint LAT_MAX = 377487360;
	localparam longint LON_MAX = 754974720;

	// distance predictor and queue of pending distances
	class distance_board;
		localparam int STAGES = 24;
		localparam longint ONE_Q30 = 64'd1073741824;
		localparam longint HALF_Q30 = 64'd536870912;
		localparam longint INV_GAIN_Q30 = 64'd652032874;
		localparam longint HALF_PI_Q30 = 64'd1686629713;
		localparam longint QUARTER_TURN = 64'd754974720;
		localparam longint FULL_TURN = 64'd3019898880;
		localparam longint unsigned DEG_TO_RAD = 64'd2398762259;
		localparam longint unsigned MILES_PER_RAD2 =
			(64'd7917509282 * 64'd1048576 + 64'd500000) / 64'd1000000;
		localparam longint unsigned DIST_SAT = 64'd4194303;

		longint arctan [32];
		logic [21:0] pending_dist [$];
		int mismatches;

		function new();
			arctan = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
				64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
				64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
				64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
				64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
				64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
				64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
				64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000};
			mismatches = 0;
		endfunction

		function longint q30_mul(longint p, longint q);
			return (p * q + HALF_Q30) >>> 30;
		endfunction

		// rotation CORDIC on a Q23 degree angle; returns sine or cosine, Q30
		function longint trig(longint deg, bit want_cos);
			longint r, quad, rem, x, y, z, xs, ys;
			r = deg % FULL_TURN;
			if (r < 0) r += FULL_TURN;
			quad = r / QUARTER_TURN;
			rem = r - quad * QUARTER_TURN;
			z = longint'((longint'(unsigned'(rem)) * DEG_TO_RAD + (64'd1 << 29)) >> 30);
			x = INV_GAIN_Q30;
			y = 0;
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= arctan[i];
				end else begin
					x += ys; y -= xs; z += arctan[i];
				end
			end
			case (quad & 3)
				0: return want_cos ? x : y;
				1: return want_cos ? -y : x;
				2: return want_cos ? -x : -y;
				default: return want_cos ? y : -x;
			endcase
		endfunction

		function longint root(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return longint'(res);
		endfunction

		// vectoring CORDIC, first quadrant
		function longint arc(longint y, longint x);
			longint z, xs, ys;
			z = 0;
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += arctan[i];
				end else begin
					x -= ys; y += xs; z -= arctan[i];
				end
			end
			return z;
		endfunction

		function logic [21:0] haversine(longint la, longint oa, longint lb, longint ob);
			longint s_lat, s_lon, c1, c2, a, ang;
			longint unsigned miles_q8;
			s_lat = trig(lb - la, 0);
			s_lon = trig(ob - oa, 0);
			c1 = trig(la * 2, 1);
			c2 = trig(lb * 2, 1);
			a = q30_mul(s_lat, s_lat) + q30_mul(q30_mul(c1, c2), q30_mul(s_lon, s_lon));
			if (a < 0) a = 0;
			if (a > ONE_Q30) a = ONE_Q30;
			ang = arc(root(longint'(unsigned'(a)) << 30),
				root(longint'(unsigned'(ONE_Q30 - a)) << 30));
			if (ang < 0) ang = 0;
			if (ang > HALF_PI_Q30) ang = HALF_PI_Q30;
			miles_q8 = (longint'(unsigned'(ang)) * MILES_PER_RAD2 + (64'd1 << 41)) >> 42;
			if (miles_q8 > DIST_SAT) miles_q8 = DIST_SAT;
			return miles_q8[21:0];
		endfunction

		function void note_pair(logic signed [29:0] la, logic signed [30:0] oa,
				logic signed [29:0] lb, logic signed [30:0] ob);
			pending_dist = {pending_dist, haversine(la, oa, lb, ob)};
		endfunction

		function void check_distance(logic [21:0] got);
			logic [21:0] want;
			if (pending_dist.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected distance transaction: %0d", got);
				return;
			end
			want = pending_dist.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("distance_miles mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [29:0] lat_a;
	logic signed [30:0] lon_a;
	logic signed [29:0] lat_b;
	logic signed [30:0] lon_b;
	logic out_valid;
	logic out_ready;
	logic [21:0] distance_miles;

	distance_board board;
	int cycles;
	int sent;
	bit hold_req;

	great_circle_distance i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.lat_a(lat_a),
		.lon_a(lon_a),
		.lat_b(lat_b),
		.lon_b(lon_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance_miles(distance_miles)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// present one pair from a falling edge, hold until taken
	task automatic send_pair(longint la, longint oa, longint lb, longint ob);
		@(negedge clk);
		in_valid = 1'b1;
		lat_a = la[29:0];
		lon_a = oa[30:0];
		lat_b = lb[29:0];
		lon_b = ob[30:0];
		do @(posedge clk); while (!in_ready);
		board.note_pair(lat_a, lon_a, lat_b, lon_b);
		sent++;
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic longint rand_coord(longint lim);
		return longint'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	task automatic send_random_pair();
		longint la, oa, lb, ob;
		int kind;
		kind = $urandom_range(0, 9);
		la = rand_coord(LAT_MAX);
		oa = rand_coord(LON_MAX);
		if (kind < 6) begin
			lb = rand_coord(LAT_MAX);
			ob = rand_coord(LON_MAX);
		end else if (kind < 8) begin
			// close neighbours: small distances
			lb = la + longint'($urandom_range(0, 4000000)) - 2000000;
			ob = oa + longint'($urandom_range(0, 4000000)) - 2000000;
		end else begin
			// raw bit patterns, periodic reduction
			la = longint'(signed'(30'($urandom())));
			oa = longint'(signed'(31'($urandom())));
			lb = longint'(signed'(30'($urandom())));
			ob = longint'(signed'(31'($urandom())));
		end
		send_pair(la, oa, lb, ob);
	endtask

	// receiver stall pattern plus one long hold-off
	initial begin
		int phase;
		out_ready = 1'b0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			phase = (phase + 1) % 64;
			if (phase < 16) out_ready = 1'b1;
			else if (phase < 40) out_ready = ($urandom_range(0, 3) != 0);
			else out_ready = ($urandom_range(0, 1) != 0);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_distance(distance_miles);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("great_circle_distance verification failed");
			$finish;
		end
	end

	initial begin
		int burst;
		board = new();
		cycles = 0;
		sent = 0;
		hold_req = 1'b0;
		in_valid = 1'b0;
		lat_a = '0;
		lon_a = '0;
		lat_b = '0;
		lon_b = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero, poles, antipodes, range limits and raw extremes
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
		send_pair(LAT_MAX, 0, LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX / 2);
		send_pair(0, 0, 1, 0);
		send_pair(0, 0, 0, 1);
		send_pair(-(1 <<< 29), -(1 <<< 30), (1 <<< 29) - 1, (1 <<< 30) - 1);
		send_pair((1 <<< 29) - 1, (1 <<< 30) - 1, -(1 <<< 29), -(1 <<< 30));
		send_pair(-(1 <<< 29), 0, -(1 <<< 29), (1 <<< 30) - 1);
		send_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 2, -LON_MAX * 2 / 3);
		send_pair(1, 1, -1, -1);
		send_pair(-1, -1, -1, -1);

		// random bursts; one long receiver hold-off midway
		while (sent < N_RANDOM + 16) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				if (sent == 600) hold_req = 1'b1;
				send_random_pair();
			end
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (board.pending_dist.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("great_circle_distance verification clean");
		end else begin
			$display("great_circle_distance verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/gcd_pkg.sv
design/gcd_sincos.sv
design/gcd_isqrt.sv
design/gcd_atan.sv
design/great_circle_distance.sv
verif/tb_great_circle_distance.sv
